[rtl/cmsg_pkg.sv]
// Shared types and constants for the cone mesh side generator.
// Depends on nothing; every other file imports it.
package cmsg_pkg;

   localparam int CORDIC_STEPS = 18;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [15:0] UNIT_NORM = 16'sd16384;
   localparam logic [22:0] MIN_VAL = 23'd655;
   localparam logic [2:0] LAST_SLOT = 3'd5;

   localparam logic [2:0] CSR_RADIUS   = 3'd0;
   localparam logic [2:0] CSR_HEIGHT   = 3'd1;
   localparam logic [2:0] CSR_SIDES    = 3'd2;
   localparam logic [2:0] CSR_CENTER_X = 3'd3;
   localparam logic [2:0] CSR_CENTER_Y = 3'd4;
   localparam logic [2:0] CSR_CENTER_Z = 3'd5;

   typedef struct packed {
      logic [7:0] idx;
      logic       err;
   } item_type;

   typedef struct packed {
      logic               err;
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic signed [23:0] cz;
      logic signed [23:0] apex_y;
      logic signed [23:0] near_x;
      logic signed [23:0] near_z;
      logic signed [23:0] far_x;
      logic signed [23:0] far_z;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
   } vset_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PDIV,
      ST_CORDIC,
      ST_MUL,
      ST_CROSS,
      ST_SHIFT,
      ST_SQUARE,
      ST_SQRT,
      ST_NDIV,
      ST_DONE
   } eng_state_type;

   // arctangent of 2^-i, 2^24 per turn
   function automatic logic [21:0] atan_step(input logic [4:0] i);
      logic [21:0] a;
      unique case (i)
         5'd0:  a = 22'd2097152;
         5'd1:  a = 22'd1238021;
         5'd2:  a = 22'd654136;
         5'd3:  a = 22'd332050;
         5'd4:  a = 22'd166669;
         5'd5:  a = 22'd83416;
         5'd6:  a = 22'd41718;
         5'd7:  a = 22'd20860;
         5'd8:  a = 22'd10430;
         5'd9:  a = 22'd5215;
         5'd10: a = 22'd2608;
         5'd11: a = 22'd1304;
         5'd12: a = 22'd652;
         5'd13: a = 22'd326;
         5'd14: a = 22'd163;
         5'd15: a = 22'd81;
         5'd16: a = 22'd41;
         5'd17: a = 22'd20;
         default: a = 22'd0;
      endcase
      return a;
   endfunction

endpackage

[rtl/cmsg_front.sv]
// Front end: accepts side indexes, flags out-of-range ones, and queues them.
// Depends on cmsg_pkg.
module cmsg_front import cmsg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_side_index,
   input  logic [8:0] n,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_pop
);

   item_type   ent_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;
   logic       push_ok;
   logic       pop_ok;

   assign req_full   = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = ent_ff[rd_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_pop && item_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push_ok) begin
            wr_ff <= !wr_ff;
         end
         if (pop_ok) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         ent_ff[wr_ff].idx <= req_side_index;
         ent_ff[wr_ff].err <= ({1'b0, req_side_index} >= n);
      end
   end

endmodule

[rtl/cmsg_engine.sv]
// Back end: phase division, CORDIC, rim offsets, slant normal with square root
// and normalizing division, all on one sequenced datapath. Depends on cmsg_pkg.
module cmsg_engine import cmsg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  item_type           item,
   output logic               item_pop,
   input  logic [8:0]         n,
   input  logic [22:0]        radius,
   input  logic [22:0]        height,
   input  logic signed [23:0] center_x,
   input  logic signed [23:0] center_y,
   input  logic signed [23:0] center_z,
   output logic               vs_valid,
   output vset_type           vs,
   input  logic               vs_ready
);

   localparam logic [4:0] PDIV_LAST   = 5'd15;
   localparam logic [4:0] NDIV_LAST   = 5'd14;
   localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
   localparam logic [4:0] MUL_LAST    = 5'd4;
   localparam logic [4:0] SQ_LAST     = 5'd3;
   localparam logic [4:0] SQRT_LAST   = 5'd31;

   eng_state_type state_ff, state_in;
   logic [4:0]  cnt_ff;
   logic [7:0]  idx_ff;
   logic        err_ff;
   logic        last_ff;
   logic        pass_ff;
   logic [1:0]  comp_ff;
   logic [15:0] phase1_ff, phase2_ff;

   logic [32:0] dv_rem_ff;
   logic [15:0] dv_low_ff;
   logic [15:0] dv_q_ff;
   logic [31:0] dv_den_ff;

   logic signed [33:0] x_ff, y_ff;
   logic signed [24:0] z_ff;
   logic signed [31:0] c1_ff, s1_ff, c2_ff, s2_ff;

   logic signed [57:0] prod_ff, t_ff;
   logic signed [24:0] dxn_ff, dzn_ff, dxf_ff, dzf_ff;
   logic [57:0] mx_ff, my_ff, mz_ff;
   logic        sgx_ff, sgy_ff, sgz_ff;
   logic [59:0] sq_ff;
   logic [61:0] sum_ff;
   logic [63:0] sq_v_ff, sq_r_ff, sq_bit_ff;
   logic [31:0] len_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff;

   function automatic logic [57:0] mag58(input logic signed [57:0] v);
      return v[57] ? 58'(-v) : 58'(v);
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      logic signed [23:0] r;
      if (v > 26'sd8388607) r = 24'sh7FFFFF;
      else if (v < -26'sd8388608) r = 24'sh800000;
      else r = v[23:0];
      return r;
   endfunction

   // effective sizes and shared combinational pieces
   logic [22:0]        r_eff, h_eff;
   logic [32:0]        dv_trial, dv_diff;
   logic               dv_ge;
   logic [15:0]        dv_q_next;
   logic signed [33:0] x_step, y_step, sx, sy;
   logic signed [24:0] z_step, atan_s;
   logic [1:0]         quad;
   logic signed [31:0] cm, sm;
   logic [15:0]        ph_start;
   logic signed [25:0] bx, bz;
   logic signed [25:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [57:0] mul_p, ny_full, rnd;
   logic signed [24:0] d_rnd;
   logic               big;
   logic [29:0]        sq_sel, nd_sel;
   logic [59:0]        sq_p;
   logic [63:0]        rb;
   logic               sq_ge;
   logic [63:0]        sq_r_next;
   logic [31:0]        len_src;
   logic [1:0]         nd_comp;
   logic [44:0]        nd_num;
   logic [14:0]        q15;
   logic               q_sgn;
   logic signed [15:0] q_signed;

   always_comb begin
      r_eff = (radius == 23'd0) ? MIN_VAL : radius;
      h_eff = (height == 23'd0) ? MIN_VAL : height;

      dv_trial  = {dv_rem_ff[31:0], dv_low_ff[15]};
      dv_diff   = dv_trial - {1'b0, dv_den_ff};
      dv_ge     = (dv_trial >= {1'b0, dv_den_ff});
      dv_q_next = {dv_q_ff[14:0], dv_ge};

      sx     = x_ff >>> cnt_ff;
      sy     = y_ff >>> cnt_ff;
      atan_s = $signed({3'b000, atan_step(cnt_ff)});
      if (!z_ff[24]) begin
         x_step = x_ff - sy;
         y_step = y_ff + sx;
         z_step = z_ff - atan_s;
      end else begin
         x_step = x_ff + sy;
         y_step = y_ff - sx;
         z_step = z_ff + atan_s;
      end
      quad = pass_ff ? phase2_ff[15:14] : phase1_ff[15:14];
      unique case (quad)
         2'd0: begin cm = x_step[31:0];    sm = y_step[31:0];    end
         2'd1: begin cm = -y_step[31:0];   sm = x_step[31:0];    end
         2'd2: begin cm = -x_step[31:0];   sm = -y_step[31:0];   end
         2'd3: begin cm = y_step[31:0];    sm = -x_step[31:0];   end
      endcase
      ph_start = pass_ff ? phase1_ff : dv_q_next;

      bx = {dxf_ff[24], dxf_ff} - {dxn_ff[24], dxn_ff};
      bz = {dzf_ff[24], dzf_ff} - {dzn_ff[24], dzn_ff};
      if (state_ff == ST_MUL) begin
         mul_a = $signed({3'b000, r_eff});
         unique case (cnt_ff[1:0])
            2'd0: mul_b = c1_ff;
            2'd1: mul_b = s1_ff;
            2'd2: mul_b = c2_ff;
            2'd3: mul_b = s2_ff;
         endcase
      end else begin
         unique case (cnt_ff[1:0])
            2'd0: begin mul_a = $signed({3'b000, h_eff});  mul_b = {{6{bz[25]}}, bz}; end
            2'd1: begin mul_a = $signed({3'b000, h_eff});  mul_b = {{6{bx[25]}}, bx}; end
            2'd2: begin mul_a = {dxn_ff[24], dxn_ff};      mul_b = {{6{bz[25]}}, bz}; end
            2'd3: begin mul_a = {dzn_ff[24], dzn_ff};      mul_b = {{6{bx[25]}}, bx}; end
         endcase
      end
      mul_p   = mul_a * mul_b;
      rnd     = prod_ff + 58'sd536870912;
      d_rnd   = rnd[54:30];
      ny_full = t_ff - prod_ff;

      big = (|mx_ff[57:30]) || (|my_ff[57:30]) || (|mz_ff[57:30]);
      unique case (cnt_ff[1:0])
         2'd0:    sq_sel = mx_ff[29:0];
         2'd1:    sq_sel = my_ff[29:0];
         default: sq_sel = mz_ff[29:0];
      endcase
      sq_p = {30'd0, sq_sel} * {30'd0, sq_sel};

      rb    = sq_r_ff + sq_bit_ff;
      sq_ge = (sq_v_ff >= rb);
      sq_r_next = sq_ge ? ((sq_r_ff >> 1) + sq_bit_ff) : (sq_r_ff >> 1);

      len_src = (state_ff == ST_SQRT) ? sq_r_next[31:0] : len_ff;
      nd_comp = (state_ff == ST_SQRT) ? 2'd0 : comp_ff + 2'd1;
      unique case (nd_comp)
         2'd0:    nd_sel = mx_ff[29:0];
         2'd1:    nd_sel = my_ff[29:0];
         default: nd_sel = mz_ff[29:0];
      endcase
      nd_num = {1'b0, nd_sel, 14'd0} + {14'd0, len_src[31:1]};

      q15 = {dv_q_ff[13:0], dv_ge};
      unique case (comp_ff)
         2'd0:    q_sgn = sgx_ff;
         2'd1:    q_sgn = sgy_ff;
         default: q_sgn = sgz_ff;
      endcase
      q_signed = q_sgn ? -$signed({1'b0, q15}) : $signed({1'b0, q15});
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_pop = 1'b0;
      vs_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               state_in = item.err ? ST_DONE : ST_PDIV;
            end
         end
         ST_PDIV: begin
            if (cnt_ff == PDIV_LAST && (pass_ff || last_ff)) state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (cnt_ff == CORDIC_LAST && pass_ff) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (cnt_ff == MUL_LAST) state_in = ST_CROSS;
         end
         ST_CROSS: begin
            if (cnt_ff == MUL_LAST) state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (!big) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (cnt_ff == SQ_LAST) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (cnt_ff == SQRT_LAST) begin
               state_in = (sq_r_next[31:0] == 32'd0) ? ST_DONE : ST_NDIV;
            end
         end
         ST_NDIV: begin
            if (cnt_ff == NDIV_LAST && comp_ff == 2'd2) state_in = ST_DONE;
         end
         ST_DONE: begin
            vs_valid = 1'b1;
            if (vs_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            idx_ff    <= item.idx;
            err_ff    <= item.err;
            last_ff   <= ({1'b0, item.idx} == n - 9'd1);
            pass_ff   <= 1'b0;
            cnt_ff    <= 5'd0;
            // numerator idx * 2^16 + n/2: top part idx, low part n/2
            dv_rem_ff <= {25'd0, item.idx};
            dv_low_ff <= {8'd0, n[8:1]};
            dv_den_ff <= {23'd0, n};
            dv_q_ff   <= 16'd0;
         end
         ST_PDIV: begin
            dv_rem_ff <= dv_ge ? dv_diff : dv_trial;
            dv_low_ff <= {dv_low_ff[14:0], 1'b0};
            dv_q_ff   <= dv_q_next;
            cnt_ff    <= cnt_ff + 5'd1;
            if (cnt_ff == PDIV_LAST) begin
               cnt_ff <= 5'd0;
               if (!pass_ff) phase1_ff <= dv_q_next;
               if (!pass_ff && !last_ff) begin
                  pass_ff   <= 1'b1;
                  dv_rem_ff <= {24'd0, {1'b0, idx_ff} + 9'd1};
                  dv_low_ff <= {8'd0, n[8:1]};
                  dv_q_ff   <= 16'd0;
               end else begin
                  // last side wraps to phase zero
                  phase2_ff <= pass_ff ? dv_q_next : 16'd0;
                  pass_ff   <= 1'b0;
                  x_ff      <= CORDIC_GAIN;
                  y_ff      <= 34'sd0;
                  z_ff      <= $signed({3'b000, ph_start[13:0], 8'd0});
               end
            end
         end
         ST_CORDIC: begin
            x_ff   <= x_step;
            y_ff   <= y_step;
            z_ff   <= z_step;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == CORDIC_LAST) begin
               cnt_ff <= 5'd0;
               if (!pass_ff) begin
                  c1_ff   <= cm;
                  s1_ff   <= sm;
                  pass_ff <= 1'b1;
                  x_ff    <= CORDIC_GAIN;
                  y_ff    <= 34'sd0;
                  z_ff    <= $signed({3'b000, phase2_ff[13:0], 8'd0});
               end else begin
                  c2_ff <= cm;
                  s2_ff <= sm;
               end
            end
         end
         ST_MUL: begin
            prod_ff <= mul_p;
            cnt_ff  <= cnt_ff + 5'd1;
            unique case (cnt_ff)
               5'd1:    dxn_ff <= d_rnd;
               5'd2:    dzn_ff <= d_rnd;
               5'd3:    dxf_ff <= d_rnd;
               5'd4:    dzf_ff <= d_rnd;
               default: ;
            endcase
            if (cnt_ff == MUL_LAST) cnt_ff <= 5'd0;
         end
         ST_CROSS: begin
            prod_ff <= mul_p;
            cnt_ff  <= cnt_ff + 5'd1;
            unique case (cnt_ff)
               5'd1: begin
                  mx_ff  <= mag58(prod_ff);
                  sgx_ff <= prod_ff[57];
               end
               5'd2: begin
                  // z component is the negated product
                  mz_ff  <= mag58(prod_ff);
                  sgz_ff <= (prod_ff > 58'sd0);
               end
               5'd3: t_ff <= prod_ff;
               5'd4: begin
                  my_ff  <= mag58(ny_full);
                  sgy_ff <= ny_full[57];
               end
               default: ;
            endcase
            if (cnt_ff == MUL_LAST) cnt_ff <= 5'd0;
         end
         ST_SHIFT: begin
            if (big) begin
               mx_ff <= mx_ff >> 1;
               my_ff <= my_ff >> 1;
               mz_ff <= mz_ff >> 1;
            end
            sum_ff <= 62'd0;
            cnt_ff <= 5'd0;
         end
         ST_SQUARE: begin
            sq_ff  <= sq_p;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff != 5'd0) sum_ff <= sum_ff + {2'b00, sq_ff};
            if (cnt_ff == SQ_LAST) begin
               cnt_ff    <= 5'd0;
               sq_v_ff   <= {2'b00, sum_ff} + {4'd0, sq_ff};
               sq_r_ff   <= 64'd0;
               sq_bit_ff <= 64'd1 << 62;
            end
         end
         ST_SQRT: begin
            if (sq_ge) sq_v_ff <= sq_v_ff - rb;
            sq_r_ff   <= sq_r_next;
            sq_bit_ff <= sq_bit_ff >> 2;
            cnt_ff    <= cnt_ff + 5'd1;
            if (cnt_ff == SQRT_LAST) begin
               len_ff  <= sq_r_next[31:0];
               cnt_ff  <= 5'd0;
               comp_ff <= 2'd0;
               qx_ff   <= 16'sd0;
               qy_ff   <= 16'sd0;
               qz_ff   <= 16'sd0;
               dv_rem_ff <= {3'd0, nd_num[44:15]};
               dv_low_ff <= {nd_num[14:0], 1'b0};
               dv_den_ff <= sq_r_next[31:0];
               dv_q_ff   <= 16'd0;
            end
         end
         ST_NDIV: begin
            dv_rem_ff <= dv_ge ? dv_diff : dv_trial;
            dv_low_ff <= {dv_low_ff[14:0], 1'b0};
            dv_q_ff   <= dv_q_next;
            cnt_ff    <= cnt_ff + 5'd1;
            if (cnt_ff == NDIV_LAST) begin
               cnt_ff <= 5'd0;
               unique case (comp_ff)
                  2'd0:    qx_ff <= q_signed;
                  2'd1:    qy_ff <= q_signed;
                  default: qz_ff <= q_signed;
               endcase
               comp_ff   <= comp_ff + 2'd1;
               dv_rem_ff <= {3'd0, nd_num[44:15]};
               dv_low_ff <= {nd_num[14:0], 1'b0};
               dv_q_ff   <= 16'd0;
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_comb begin
      vs.err    = err_ff;
      vs.cx     = center_x;
      vs.cy     = center_y;
      vs.cz     = center_z;
      vs.apex_y = sat24({center_y[23], center_y[23], center_y} + {3'b000, h_eff});
      vs.near_x = sat24({center_x[23], center_x[23], center_x} + {dxn_ff[24], dxn_ff});
      vs.near_z = sat24({center_z[23], center_z[23], center_z} + {dzn_ff[24], dzn_ff});
      vs.far_x  = sat24({center_x[23], center_x[23], center_x} + {dxf_ff[24], dxf_ff});
      vs.far_z  = sat24({center_z[23], center_z[23], center_z} + {dzf_ff[24], dzf_ff});
      vs.qx     = qx_ff;
      vs.qy     = qy_ff;
      vs.qz     = qz_ff;
   end

endmodule

[rtl/cmsg_emit.sv]
// Result bank: holds one side's vertex set and hands out its beats in slot order.
// Depends on cmsg_pkg.
module cmsg_emit import cmsg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               vs_valid,
   input  vset_type           vs,
   output logic               vs_ready,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [23:0] rsp_pos_x,
   output logic signed [23:0] rsp_pos_y,
   output logic signed [23:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [2:0]         rsp_vertex_slot,
   output logic               rsp_last_of_side,
   output logic               rsp_index_error
);

   vset_type   bank_ff;
   logic       valid_ff;
   logic [2:0] slot_ff;
   logic       done_beat;

   assign vs_ready  = !valid_ff;
   assign rsp_empty = !valid_ff;
   assign done_beat = bank_ff.err || (slot_ff == LAST_SLOT);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= 3'd0;
      end else if (!valid_ff) begin
         valid_ff <= vs_valid;
         slot_ff  <= 3'd0;
      end else if (rsp_pop) begin
         if (done_beat) begin
            valid_ff <= 1'b0;
            slot_ff  <= 3'd0;
         end else begin
            slot_ff <= slot_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!valid_ff && vs_valid) begin
         bank_ff <= vs;
      end
   end

   always_comb begin
      rsp_vertex_slot  = bank_ff.err ? 3'd0 : slot_ff;
      rsp_last_of_side = done_beat;
      rsp_index_error  = bank_ff.err;
      rsp_pos_x  = bank_ff.cx;
      rsp_pos_y  = bank_ff.cy;
      rsp_pos_z  = bank_ff.cz;
      rsp_norm_x = 16'sd0;
      rsp_norm_y = -UNIT_NORM;
      rsp_norm_z = 16'sd0;
      unique case (slot_ff)
         3'd1, 3'd5: begin
            rsp_pos_x = bank_ff.near_x;
            rsp_pos_z = bank_ff.near_z;
         end
         3'd2, 3'd4: begin
            rsp_pos_x = bank_ff.far_x;
            rsp_pos_z = bank_ff.far_z;
         end
         3'd3: rsp_pos_y = bank_ff.apex_y;
         default: ;
      endcase
      if (slot_ff > 3'd2) begin
         rsp_norm_x = bank_ff.qx;
         rsp_norm_y = bank_ff.qy;
         rsp_norm_z = bank_ff.qz;
      end
      if (bank_ff.err) begin
         rsp_pos_x  = 24'sd0;
         rsp_pos_y  = 24'sd0;
         rsp_pos_z  = 24'sd0;
         rsp_norm_x = 16'sd0;
         rsp_norm_y = 16'sd0;
         rsp_norm_z = 16'sd0;
      end
   end

endmodule

[rtl/cone_mesh_side_generator_core.sv]
// Cone mesh side generator: six vertices per side index, out-of-range index gives one
// flagged beat. The last side skips the second phase division, a degenerate slant the
// normalizing division; a flagged index goes straight to the result bank. The engine
// finishes one side before it takes another, on its single shared divider, CORDIC and
// square-root datapath. Six result beats follow, one per cycle while rsp_pop is held.
// Synchronous active-high reset restores the register defaults and empties both queues.
module cone_mesh_side_generator_core import cmsg_pkg::*; #(
   parameter int MAX_SIDES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_side_index,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [23:0] rsp_pos_x,
   output logic signed [23:0] rsp_pos_y,
   output logic signed [23:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [2:0]         rsp_vertex_slot,
   output logic               rsp_last_of_side,
   output logic               rsp_index_error,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data
);

   logic [22:0]        radius_ff, height_ff;
   logic [8:0]         sides_ff;
   logic signed [23:0] center_x_ff, center_y_ff, center_z_ff;
   logic [8:0]         n_eff;
   logic               item_valid, item_pop, vs_valid, vs_ready;
   item_type           item;
   vset_type           vs;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= 23'd65536;
         height_ff   <= 23'd65536;
         sides_ff    <= 9'd3;
         center_x_ff <= 24'sd0;
         center_y_ff <= 24'sd0;
         center_z_ff <= 24'sd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIUS:   radius_ff   <= csr_data[22:0];
            CSR_HEIGHT:   height_ff   <= csr_data[22:0];
            CSR_SIDES:    sides_ff    <= csr_data[8:0];
            CSR_CENTER_X: center_x_ff <= csr_data;
            CSR_CENTER_Y: center_y_ff <= csr_data;
            CSR_CENTER_Z: center_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      n_eff = sides_ff;
      if (sides_ff < 9'd3) n_eff = 9'd3;
      if ({23'd0, sides_ff} > MAX_SIDES) n_eff = 9'(MAX_SIDES);
   end

   cmsg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_side_index (req_side_index),
      .n              (n_eff),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop)
   );

   cmsg_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .n          (n_eff),
      .radius     (radius_ff),
      .height     (height_ff),
      .center_x   (center_x_ff),
      .center_y   (center_y_ff),
      .center_z   (center_z_ff),
      .vs_valid   (vs_valid),
      .vs         (vs),
      .vs_ready   (vs_ready)
   );

   cmsg_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .vs_valid         (vs_valid),
      .vs               (vs),
      .vs_ready         (vs_ready),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_norm_x       (rsp_norm_x),
      .rsp_norm_y       (rsp_norm_y),
      .rsp_norm_z       (rsp_norm_z),
      .rsp_vertex_slot  (rsp_vertex_slot),
      .rsp_last_of_side (rsp_last_of_side),
      .rsp_index_error  (rsp_index_error)
   );

endmodule

[tb/sv/cone_mesh_side_generator_core_tb.sv]
// Self-checking bench for cone_mesh_side_generator_core: random side indexes in, vertex beats
// checked against an in-bench fixed-point cone model. Depends on cmsg_pkg and the core RTL.
module cone_mesh_side_generator_core_tb;
   import cmsg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [23:0] px, py, pz;
      logic signed [15:0] nx, ny, nz;
      logic [2:0]         slot;
      logic               last, err;
   } vertex_type;

   typedef struct {
      bit         is_cfg;
      logic [2:0] reg_idx;
      logic [23:0] data;
      logic [7:0] side;
   } op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic [7:0] req_side_index = '0;
   logic rsp_pop = 1'b0;
   logic csr_valid = 1'b0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_data = '0;
   logic req_full, rsp_empty, csr_ready;
   logic signed [23:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [2:0] rsp_vertex_slot;
   logic rsp_last_of_side, rsp_index_error;

   cone_mesh_side_generator_core DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model copy of the registers
   logic [22:0] m_radius = 23'd65536, m_height = 23'd65536;
   logic [8:0]  m_sides = 9'd3;
   logic signed [23:0] m_cx = '0, m_cy = '0, m_cz = '0;

   vertex_type expected_vertices[$];
   op_type pending_ops[$];
   int errors = 0, sides_sent = 0, flagged_sent = 0, vertices_seen = 0;
   longint cycles = 0;

   localparam longint ATAN[18] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
      20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20};

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic void rotate(longint unsigned ph, output longint c, output longint s);
      longint x, y, z, nx;
      int q;
      q = int'((ph >> 14) & 3);
      z = (ph & 16'h3FFF) << 8;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 18; i++) begin
         if (z >= 0) begin
            nx = x - asr(y, i); y = y + asr(x, i); z -= ATAN[i];
         end else begin
            nx = x + asr(y, i); y = y - asr(x, i); z += ATAN[i];
         end
         x = nx;
      end
      case (q)
         0: begin c = x; s = y; end
         1: begin c = -y; s = x; end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned absval(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unit_comp(longint v, int sh, longint unsigned len);
      longint unsigned m;
      longint q;
      m = absval(v) >> sh;
      q = longint'((m * 16384 + len / 2) / len);
      return v < 0 ? -q : q;
   endfunction

   function automatic vertex_type vtx(longint px, py, pz, nx, ny, nz, int slot, bit last,
                                      bit err);
      vertex_type v;
      v.px = px[23:0]; v.py = py[23:0]; v.pz = pz[23:0];
      v.nx = nx[15:0]; v.ny = ny[15:0]; v.nz = nz[15:0];
      v.slot = slot[2:0]; v.last = last; v.err = err;
      return v;
   endfunction

   task automatic queue_vertex(vertex_type v);
      expected_vertices = {expected_vertices, v};
   endtask

   task automatic queue_op(op_type o);
      pending_ops = {pending_ops, o};
   endtask

   task automatic predict_side(logic [7:0] side);
      longint unsigned n, idx, a1, a2, m, sum, len;
      longint r, h, cx, cy, cz, c1, s1, c2, s2, dxn, dzn, dxf, dzf;
      longint bx, bz, nx, ny, nz, qx, qy, qz;
      int sh;
      idx = side;
      n = m_sides < 3 ? 3 : (m_sides > 256 ? 256 : m_sides);
      if (idx >= n) begin
         queue_vertex(vtx(0, 0, 0, 0, 0, 0, 0, 1, 1));
         return;
      end
      r = m_radius == 0 ? 655 : m_radius;
      h = m_height == 0 ? 655 : m_height;
      cx = m_cx; cy = m_cy; cz = m_cz;
      a1 = (((idx << 16) + n / 2) / n) & 16'hFFFF;
      a2 = (idx == n - 1) ? 0 : ((((idx + 1) << 16) + n / 2) / n) & 16'hFFFF;
      rotate(a1, c1, s1);
      rotate(a2, c2, s2);
      dxn = asr(r * c1 + (64'sd1 << 29), 30);
      dzn = asr(r * s1 + (64'sd1 << 29), 30);
      dxf = asr(r * c2 + (64'sd1 << 29), 30);
      dzf = asr(r * s2 + (64'sd1 << 29), 30);
      bx = dxf - dxn; bz = dzf - dzn;
      nx = h * bz;
      ny = -dzn * bx + dxn * bz;
      nz = -(h * bx);
      m = absval(nx);
      if (absval(ny) > m) m = absval(ny);
      if (absval(nz) > m) m = absval(nz);
      sh = 0;
      while ((m >> sh) >= (64'd1 << 30)) sh++;
      sum = (absval(nx) >> sh) * (absval(nx) >> sh) + (absval(ny) >> sh) * (absval(ny) >> sh)
          + (absval(nz) >> sh) * (absval(nz) >> sh);
      len = root64(sum);
      qx = 0; qy = 0; qz = 0;
      if (len != 0) begin
         qx = unit_comp(nx, sh, len);
         qy = unit_comp(ny, sh, len);
         qz = unit_comp(nz, sh, len);
      end
      queue_vertex(vtx(cx, cy, cz, 0, -16384, 0, 0, 0, 0));
      queue_vertex(vtx(sat24(cx + dxn), cy, sat24(cz + dzn), 0, -16384, 0, 1, 0, 0));
      queue_vertex(vtx(sat24(cx + dxf), cy, sat24(cz + dzf), 0, -16384, 0, 2, 0, 0));
      queue_vertex(vtx(cx, sat24(cy + h), cz, qx, qy, qz, 3, 0, 0));
      queue_vertex(vtx(sat24(cx + dxf), cy, sat24(cz + dzf), qx, qy, qz, 4, 0, 0));
      queue_vertex(vtx(sat24(cx + dxn), cy, sat24(cz + dzn), qx, qy, qz, 5, 1, 0));
   endtask

   task automatic apply_reg(logic [2:0] i, logic [23:0] d);
      case (i)
         CSR_RADIUS:   m_radius = d[22:0];
         CSR_HEIGHT:   m_height = d[22:0];
         CSR_SIDES:    m_sides = d[8:0];
         CSR_CENTER_X: m_cx = d;
         CSR_CENTER_Y: m_cy = d;
         CSR_CENTER_Z: m_cz = d;
         default: ;
      endcase
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: config beats only when nothing is in flight, settle first
   int drv_wait = 0;
   int settle = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            predict_side(req_side_index);
            if (req_side_index < (m_sides < 3 ? 3 : m_sides)) sides_sent++;
            else flagged_sent++;
         end
         if (csr_valid && csr_ready) apply_reg(csr_index, csr_data);
         if ((req_push && req_full) || (csr_valid && !csr_ready)) begin
            // hold the beat
         end else if (drv_wait > 0) begin
            req_push <= 1'b0; csr_valid <= 1'b0;
            drv_wait--;
         end else if (pending_ops.size() == 0) begin
            req_push <= 1'b0; csr_valid <= 1'b0;
         end else if (pending_ops[0].is_cfg) begin
            req_push <= 1'b0;
            if (expected_vertices.size() != 0 || req_push) begin
               csr_valid <= 1'b0; settle = 0;
            end else if (settle < 200) begin
               csr_valid <= 1'b0; settle++;
            end else begin
               csr_valid <= 1'b1;
               csr_index <= pending_ops[0].reg_idx;
               csr_data <= pending_ops[0].data;
               void'(pending_ops.pop_front());
               settle = 0;
            end
         end else begin
            csr_valid <= 1'b0;
            req_push <= 1'b1;
            req_side_index <= pending_ops[0].side;
            void'(pending_ops.pop_front());
            drv_wait = gap_len();
         end
      end
   end

   // monitor with random pop stalls
   int pop_wait = 0;
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            vertices_seen++;
            if (expected_vertices.size() == 0) begin
               $error("unexpected beat slot %0d", rsp_vertex_slot);
               errors++;
            end else begin
               vertex_type e;
               e = expected_vertices.pop_front();
               if (rsp_pos_x !== e.px) begin
                  $error("pos_x exp %0d got %0d", e.px, rsp_pos_x); errors++; end
               if (rsp_pos_y !== e.py) begin
                  $error("pos_y exp %0d got %0d", e.py, rsp_pos_y); errors++; end
               if (rsp_pos_z !== e.pz) begin
                  $error("pos_z exp %0d got %0d", e.pz, rsp_pos_z); errors++; end
               if (rsp_norm_x !== e.nx) begin
                  $error("norm_x exp %0d got %0d", e.nx, rsp_norm_x); errors++; end
               if (rsp_norm_y !== e.ny) begin
                  $error("norm_y exp %0d got %0d", e.ny, rsp_norm_y); errors++; end
               if (rsp_norm_z !== e.nz) begin
                  $error("norm_z exp %0d got %0d", e.nz, rsp_norm_z); errors++; end
               if (rsp_vertex_slot !== e.slot) begin
                  $error("vertex_slot exp %0d got %0d", e.slot, rsp_vertex_slot); errors++; end
               if (rsp_last_of_side !== e.last) begin
                  $error("last_of_side exp %0d got %0d", e.last, rsp_last_of_side); errors++; end
               if (rsp_index_error !== e.err) begin
                  $error("index_error exp %0d got %0d", e.err, rsp_index_error); errors++; end
            end
         end
         if (pop_wait > 0) begin
            rsp_pop <= 1'b0; pop_wait--;
         end else begin
            rsp_pop <= 1'b1;
            pop_wait = gap_len();
         end
      end
   end

   task automatic add_cfg(logic [2:0] i, logic [23:0] d);
      op_type o;
      o.is_cfg = 1; o.reg_idx = i; o.data = d; o.side = '0;
      queue_op(o);
   endtask

   task automatic add_side(logic [7:0] s);
      op_type o;
      o.is_cfg = 0; o.reg_idx = '0; o.data = '0; o.side = s;
      queue_op(o);
   endtask

   initial begin
      int n_eff;
      // directed: reset shape, extremes, wrap side, out of range, clamps
      add_side(8'd0); add_side(8'd1); add_side(8'd2); add_side(8'd3); add_side(8'hFF);
      add_cfg(CSR_RADIUS, 24'd0); add_cfg(CSR_HEIGHT, 24'd0); add_cfg(CSR_SIDES, 24'd0);
      add_side(8'd0); add_side(8'd2); add_side(8'd3);
      add_cfg(CSR_RADIUS, 24'h7FFFFF); add_cfg(CSR_HEIGHT, 24'h7FFFFF);
      add_cfg(CSR_SIDES, 24'd256);
      add_cfg(CSR_CENTER_X, 24'h7FFFFF); add_cfg(CSR_CENTER_Y, 24'h800000);
      add_cfg(CSR_CENTER_Z, 24'h7FFFFF);
      add_side(8'd0); add_side(8'd63); add_side(8'd128); add_side(8'hFF); add_side(8'hAA);
      add_cfg(CSR_SIDES, 24'd511); add_cfg(CSR_CENTER_Y, 24'h7FFFFF);
      add_side(8'h55); add_side(8'hFF);
      add_cfg(CSR_RADIUS, 24'd1); add_cfg(CSR_HEIGHT, 24'd1); add_cfg(CSR_SIDES, 24'd4);
      add_side(8'd0); add_side(8'd3); add_side(8'd4);
      // random phases, each with a fresh register setting
      for (int ph = 0; ph < 8; ph++) begin
         add_cfg(CSR_RADIUS, 24'($urandom_range(0, 8388607)));
         add_cfg(CSR_HEIGHT, 24'($urandom_range(0, 8388607)));
         n_eff = (ph % 3 == 0) ? $urandom_range(0, 511) : $urandom_range(3, 24);
         add_cfg(CSR_SIDES, 24'(n_eff));
         add_cfg(CSR_CENTER_X, 24'($urandom));
         add_cfg(CSR_CENTER_Y, 24'($urandom));
         add_cfg(CSR_CENTER_Z, 24'($urandom));
         if (n_eff < 3) n_eff = 3;
         if (n_eff > 256) n_eff = 256;
         for (int k = 0; k < 17; k++)
            if ($urandom_range(0, 9) == 0) add_side(8'($urandom_range(0, 255)));
            else add_side(8'($urandom_range(0, n_eff - 1)));
      end
      add_cfg(CSR_RADIUS, 24'd65536); add_cfg(CSR_HEIGHT, 24'd65536);
      add_cfg(CSR_SIDES, 24'd3);
      add_cfg(CSR_CENTER_X, 24'd0); add_cfg(CSR_CENTER_Y, 24'd0); add_cfg(CSR_CENTER_Z, 24'd0);
      add_side(8'd2);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_ops.size() == 0);
      @(posedge clock);
      wait (!req_push && !csr_valid && expected_vertices.size() == 0);
      repeat (200) @(posedge clock);
      $display("Covered %0d sides and %0d flagged indexes, %0d vertex beats checked.",
               sides_sent, flagged_sent, vertices_seen);
      if (errors == 0 && expected_vertices.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      wait (cycles > 400000);
      $display("DONE: errors detected");
      $finish;
   end
endmodule

[filelist.f]
rtl/cmsg_pkg.sv
rtl/cmsg_front.sv
rtl/cmsg_engine.sv
rtl/cmsg_emit.sv
rtl/cone_mesh_side_generator_core.sv
tb/sv/cone_mesh_side_generator_core_tb.sv
